// ----- rtl/core/esa_pkg.sv -----
// ----------------------------------------------------------------------------
// esa_pkg: shared definitions for the entity slot allocator
// Field widths, request and status codes, default sizes and the
// controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package esa_pkg;

  // default table sizes
  localparam int ESA_ENTITY_SLOTS    = 256;
  localparam int ESA_COMPONENT_TYPES = 32;

  // slots per group in the free-slot search
  localparam int ESA_GROUP = 16;

  // fixed field widths
  localparam int OP_W  = 3;
  localparam int ID_W  = 8;
  localparam int CI_W  = 5;
  localparam int ST_W  = 2;
  localparam int CNT_W = 8;

  // request codes
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_ADD    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_HAS    = 3'd4,
    OP_VALID  = 3'd5
  } esa_op_t;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } esa_status_t;

  // controller commands to the datapath
  typedef struct packed {
    logic accept;  // request transfer: latch it and read the mask
    logic commit;  // finish the request: update state, load the result
  } esa_cmd_t;

endpackage

// ----- rtl/core/esa_ifs.sv -----
// ----------------------------------------------------------------------------
// esa_ifs: request and result channels
// Valid/ready channels carrying one request or one result per transfer.
// ----------------------------------------------------------------------------
interface esa_in_if import esa_pkg::*;;
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  logic [ID_W-1:0] entity_id;
  logic [CI_W-1:0] component_index;

  modport source (output valid, operation, entity_id, component_index, input ready);
  modport sink   (input valid, operation, entity_id, component_index, output ready);
endinterface

interface esa_out_if import esa_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [ID_W-1:0]  new_entity;
  logic             answer;
  logic             freed;
  logic [CNT_W-1:0] live_count;

  modport source (output valid, status, new_entity, answer, freed, live_count,
                  input ready);
  modport sink   (input valid, status, new_entity, answer, freed, live_count,
                  output ready);
endinterface

// ----- rtl/core/esa_ram.sv -----
// ----------------------------------------------------------------------------
// esa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds between reads.
// ----------------------------------------------------------------------------
module esa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/esa_ctrl.sv -----
// ----------------------------------------------------------------------------
// esa_ctrl: request sequencer
// Two-state controller: take a request, then finish it once the result
// register is free. Drives the handshakes and the datapath commands.
// ----------------------------------------------------------------------------
module esa_ctrl import esa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output esa_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // handshake and commands
  assign in_ready   = (state_r == S_IDLE);
  assign out_free   = !out_valid_r || out_ready;
  assign cmd.accept = in_valid && in_ready;
  assign cmd.commit = (state_r == S_EXEC) && out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/esa_datapath.sv -----
// ----------------------------------------------------------------------------
// esa_datapath: slot table, mask memory and free-slot search
// Holds the active bits and live count in flops, the component masks in
// RAM, a two-stage lowest-free-slot search and the result register.
// ----------------------------------------------------------------------------
module esa_datapath import esa_pkg::*; #(
  parameter int ENTITY_SLOTS    = ESA_ENTITY_SLOTS,
  parameter int COMPONENT_TYPES = ESA_COMPONENT_TYPES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  esa_cmd_t         cmd,
  input  logic [OP_W-1:0]  in_operation,
  input  logic [ID_W-1:0]  in_entity_id,
  input  logic [CI_W-1:0]  in_component_index,
  output logic [ST_W-1:0]  out_status,
  output logic [ID_W-1:0]  out_new_entity,
  output logic             out_answer,
  output logic             out_freed,
  output logic [CNT_W-1:0] out_live_count
);

  localparam int SLOT_W   = $clog2(ENTITY_SLOTS);
  localparam int ID_EXT_W = (SLOT_W > ID_W) ? SLOT_W : ID_W;
  localparam int NGRP     = (ENTITY_SLOTS + ESA_GROUP - 1) / ESA_GROUP;
  localparam int GRP_W    = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int GIDX_W   = $clog2(ESA_GROUP);
  localparam int PAD      = NGRP * ESA_GROUP;

  // table state
  logic [ENTITY_SLOTS-1:0] active_r, active_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;

  // latched request
  logic [OP_W-1:0] op_r;
  logic [ID_W-1:0] id_r;
  logic [CI_W-1:0] ci_r;

  // search
  logic [PAD-1:0]    free_vec;
  logic [NGRP-1:0]   grp_any_r, grp_any_nxt;
  logic [GIDX_W-1:0] grp_idx_r [NGRP];
  logic [GIDX_W-1:0] grp_idx_nxt [NGRP];
  logic              found;
  logic [GRP_W-1:0]  gsel;
  logic [GIDX_W-1:0] isel;
  logic [SLOT_W-1:0] grant_slot;

  // request decode
  logic [ID_EXT_W-1:0]        id_ext, in_id_ext;
  logic [SLOT_W-1:0]          id_idx;
  logic                       id_valid;
  logic [COMPONENT_TYPES-1:0] comp_bit;
  logic [COMPONENT_TYPES-1:0] mask_rd;
  logic [COMPONENT_TYPES-1:0] remain_mask;

  // result and write-back
  logic [ST_W-1:0]            st;
  logic [ID_W-1:0]            grant;
  logic                       ans;
  logic                       fr;
  logic                       mem_we;
  logic [SLOT_W-1:0]          mem_wa;
  logic [COMPONENT_TYPES-1:0] mem_wd;

  logic [ST_W-1:0]  status_r;
  logic [ID_W-1:0]  new_entity_r;
  logic             answer_r;
  logic             freed_r;
  logic [CNT_W-1:0] live_count_r;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= in_operation;
      id_r <= in_entity_id;
      ci_r <= in_component_index;
    end
  end

  // mask memory, read on request transfer, written on finish
  assign in_id_ext = ID_EXT_W'(in_entity_id);

  esa_ram #(
    .WIDTH (COMPONENT_TYPES),
    .DEPTH (ENTITY_SLOTS)
  ) u_mask_ram (
    .clk     (clk),
    .wr_en   (cmd.commit && mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (cmd.accept),
    .rd_addr (in_id_ext[SLOT_W-1:0]),
    .rd_data (mask_rd)
  );

  // free vector: slot 0 and padding count as busy
  always_comb begin
    free_vec                   = '0;
    free_vec[ENTITY_SLOTS-1:0] = ~active_r;
    free_vec[0]                = 1'b0;
  end

  // search stage one: per-group any-free flag and lowest free offset
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_nxt[g] = |free_vec[g*ESA_GROUP +: ESA_GROUP];
      grp_idx_nxt[g] = '0;
      for (int j = ESA_GROUP - 1; j >= 0; j--) begin
        if (free_vec[g*ESA_GROUP + j]) grp_idx_nxt[g] = GIDX_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any_r <= grp_any_nxt;
    for (int g = 0; g < NGRP; g++) begin
      grp_idx_r[g] <= grp_idx_nxt[g];
    end
  end

  // search stage two: lowest group holding a free slot
  always_comb begin
    found = 1'b0;
    gsel  = '0;
    isel  = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        found = 1'b1;
        gsel  = GRP_W'(g);
        isel  = grp_idx_r[g];
      end
    end
  end

  assign grant_slot = SLOT_W'({gsel, isel});

  // named entity check and component bit
  assign id_ext   = ID_EXT_W'(id_r);
  assign id_idx   = id_ext[SLOT_W-1:0];
  assign id_valid = (id_r != '0) && (32'(id_r) < 32'(ENTITY_SLOTS)) && active_r[id_idx];
  assign comp_bit = (32'(ci_r) < 32'(COMPONENT_TYPES)) ?
                    (COMPONENT_TYPES'(1) << ci_r) : '0;
  assign remain_mask = mask_rd & ~comp_bit;

  // request execution
  always_comb begin
    st         = ST_OK;
    grant      = '0;
    ans        = 1'b0;
    fr         = 1'b0;
    active_nxt = active_r;
    count_nxt  = count_r;
    mem_we     = 1'b0;
    mem_wa     = id_idx;
    mem_wd     = mask_rd;
    case (op_r)
      OP_ALLOC: begin
        if (found) begin
          active_nxt[grant_slot] = 1'b1;
          count_nxt              = count_r + 1'b1;
          grant                  = ID_W'(grant_slot);
          mem_we                 = 1'b1;
          mem_wa                 = grant_slot;
          mem_wd                 = '0;
        end else begin
          st = ST_FULL;
        end
      end
      OP_FREE: begin
        if (id_valid) begin
          active_nxt[id_idx] = 1'b0;
          count_nxt          = count_r - 1'b1;
          fr                 = 1'b1;
          mem_we             = 1'b1;
          mem_wd             = '0;
        end else begin
          st = ST_INVALID;
        end
      end
      OP_ADD: begin
        if (id_valid) begin
          mem_we = 1'b1;
          mem_wd = mask_rd | comp_bit;
        end else begin
          st = ST_INVALID;
        end
      end
      OP_REMOVE: begin
        if (id_valid) begin
          mem_we = 1'b1;
          mem_wd = remain_mask;
          // last component gone: the entity is released
          if (remain_mask == '0) begin
            active_nxt[id_idx] = 1'b0;
            count_nxt          = count_r - 1'b1;
            fr                 = 1'b1;
          end
        end else begin
          st = ST_INVALID;
        end
      end
      OP_HAS: begin
        if (id_valid) begin
          ans = |(mask_rd & comp_bit);
        end else begin
          st = ST_INVALID;
        end
      end
      OP_VALID: begin
        ans = id_valid;
      end
      default: begin
      end
    endcase
  end

  // table state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      count_r  <= '0;
    end else if (cmd.commit) begin
      active_r <= active_nxt;
      count_r  <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r     <= st;
      new_entity_r <= grant;
      answer_r     <= ans;
      freed_r      <= fr;
      live_count_r <= count_nxt;
    end
  end

  assign out_status     = status_r;
  assign out_new_entity = new_entity_r;
  assign out_answer     = answer_r;
  assign out_freed      = freed_r;
  assign out_live_count = live_count_r;

endmodule

// ----- rtl/core/entity_slot_allocator_top.sv -----
// ----------------------------------------------------------------------------
// entity_slot_allocator_top: lowest-free entity slot allocator
// Grants entity slots from 1 upward and tracks a component bitmask per slot.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request (operation, entity_id, component_index) per
//   transfer; out_ch returns exactly one result per request, in order.
//   In the transfer cycle a request reads the slot's mask
//   from RAM and registers the first stage of the lowest-free-slot search;
//   in the execute state the search completes, the table is updated and the
//   result register is loaded. Result valid rises when the result register
//   is loaded; a new request is not taken until the previous one finishes,
//   since the mask read-modify-write goes through the single RAM.
//   The result register decouples the sides: a new request is taken while
//   a result waits; if the receiver stalls, the following request waits in
//   the execute state until the result register is free, and in_ch.ready
//   stays low meanwhile.
//   Reset (rst_n low, synchronous) clears every active bit and the live
//   count at once; no clearing pass. Masks are rewritten on each grant.
// ----------------------------------------------------------------------------
module entity_slot_allocator_top import esa_pkg::*; #(
  parameter int ENTITY_SLOTS    = ESA_ENTITY_SLOTS,
  parameter int COMPONENT_TYPES = ESA_COMPONENT_TYPES
) (
  input  logic      clk,
  input  logic      rst_n,
  esa_in_if.sink    in_ch,
  esa_out_if.source out_ch
);

  esa_cmd_t cmd;

  // sequencer
  esa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // table and result datapath
  esa_datapath #(
    .ENTITY_SLOTS    (ENTITY_SLOTS),
    .COMPONENT_TYPES (COMPONENT_TYPES)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_operation       (in_ch.operation),
    .in_entity_id       (in_ch.entity_id),
    .in_component_index (in_ch.component_index),
    .out_status         (out_ch.status),
    .out_new_entity     (out_ch.new_entity),
    .out_answer         (out_ch.answer),
    .out_freed          (out_ch.freed),
    .out_live_count     (out_ch.live_count)
  );

endmodule

// ----- rtl/core/esa_checker.sv -----
// ----------------------------------------------------------------------------
// esa_checker: port-level checks for the entity slot allocator
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module esa_checker import esa_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ST_W-1:0]  out_status,
  input logic [ID_W-1:0]  out_new_entity,
  input logic             out_answer,
  input logic             out_freed,
  input logic [CNT_W-1:0] out_live_count
);

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_new_entity) && $stable(out_answer) && $stable(out_freed) &&
      $stable(out_live_count))
    else $error("result changed while stalled");

  // a request transfer keeps the block busy for the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous still in work");

  // full table grants nothing, frees nothing and answers nothing
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |->
      (out_new_entity == '0) && !out_freed && !out_answer)
    else $error("full result carries a grant or release");

  // a release is a successful request with no grant or answer
  a_freed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_freed |->
      (out_status == ST_OK) && (out_new_entity == '0) && !out_answer)
    else $error("release reported with wrong companion fields");

  // a granted slot comes with ok status and nothing else
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_new_entity != '0) |->
      (out_status == ST_OK) && !out_freed && !out_answer)
    else $error("grant reported with wrong companion fields");

endmodule

bind entity_slot_allocator_top esa_checker u_esa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_new_entity (out_ch.new_entity),
  .out_answer     (out_ch.answer),
  .out_freed      (out_ch.freed),
  .out_live_count (out_ch.live_count)
);
